// ===== rtl/swmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SAMPLE_WIDTH  = 24;
    localparam int TAPS_W        = 6;

    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int LEN_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int OUT_W         = SAMPLE_WIDTH + 1;
    localparam int IN_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [LEN_W-1:0]        t_len;
    typedef logic [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [OUT_W-1:0]        t_result;

    typedef struct packed {
        logic  start;
        t_addr base;
        t_len  len;
    } t_rank_req;

    typedef struct packed {
        logic    done;
        t_result value;
    } t_rank_rsp;

endpackage

// ===== rtl/swmf_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_rank
// history memory and bit-serial rank selector for the window median
// ----------------------------------------------------------------------------
module swmf_rank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  swmf_pkg::t_addr     i_wr_addr,
    input  swmf_pkg::t_sample   i_wr_data,
    input  swmf_pkg::t_rank_req i_req,
    input  logic                i_ack,
    output swmf_pkg::t_rank_rsp o_rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    swmf_pkg::t_sample r_mem [swmf_pkg::HISTORY_DEPTH];
    swmf_pkg::t_sample r_rd_data;
    swmf_pkg::t_addr   w_rd_addr;

    logic [1:0]        r_state, n_state;
    swmf_pkg::t_addr   r_base, n_base;
    swmf_pkg::t_len    r_len, n_len;
    swmf_pkg::t_len    r_k, n_k;
    swmf_pkg::t_len    r_cnt, n_cnt;
    swmf_pkg::t_len    r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic              r_even, n_even;
    swmf_pkg::t_sample r_prefix, n_prefix;
    swmf_pkg::t_sample r_mask, n_mask;
    swmf_pkg::t_sample r_bitsel, n_bitsel;
    swmf_pkg::t_sample r_min, n_min;
    logic              r_min_vld, n_min_vld;
    swmf_pkg::t_result r_value, n_value;

    logic                   w_issue;
    logic                   w_pass_end;
    logic                   w_match;
    logic                   w_zero;
    swmf_pkg::t_addr        w_idx_a;
    logic [swmf_pkg::ADDR_W:0] w_wrap_addr;
    swmf_pkg::t_sample      w_upper;

    // newest-first walk backward from the base slot
    assign w_idx_a     = w_issue ? r_idx[swmf_pkg::ADDR_W-1:0] : '0;
    assign w_wrap_addr = {1'b0, r_base} + (swmf_pkg::ADDR_W + 1)'(swmf_pkg::HISTORY_DEPTH)
                         - {1'b0, w_idx_a};
    assign w_rd_addr   = (w_idx_a > r_base) ? w_wrap_addr[swmf_pkg::ADDR_W-1:0]
                                            : r_base - w_idx_a;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_issue    = ((r_state == ST_SCAN) || (r_state == ST_FINAL)) && (r_idx < r_len);
    assign w_pass_end = (r_idx == r_len) && !r_rd_vld;
    assign w_match    = ((r_rd_data ^ r_prefix) & r_mask) == '0;
    assign w_zero     = (r_rd_data & r_bitsel) == '0;
    assign w_upper    = (r_cnt > (r_len >> 1)) ? r_prefix : r_min;

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_len     = r_len;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_idx     = w_issue ? r_idx + 1'b1 : r_idx;
        n_rd_vld  = w_issue;
        n_even    = r_even;
        n_prefix  = r_prefix;
        n_mask    = r_mask;
        n_bitsel  = r_bitsel;
        n_min     = r_min;
        n_min_vld = r_min_vld;
        n_value   = r_value;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_base   = i_req.base;
                    n_len    = i_req.len;
                    n_even   = ~i_req.len[0];
                    n_k      = i_req.len[0] ? (i_req.len >> 1) : (i_req.len >> 1) - 1'b1;
                    n_prefix = '0;
                    n_mask   = '0;
                    n_bitsel = {1'b1, {(swmf_pkg::SAMPLE_WIDTH - 1){1'b0}}};
                    n_cnt    = '0;
                    n_idx    = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && w_match && w_zero) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (w_pass_end) begin
                    if (r_k >= r_cnt) begin
                        n_prefix = r_prefix | r_bitsel;
                        n_k      = r_k - r_cnt;
                    end
                    n_mask   = r_mask | r_bitsel;
                    n_bitsel = r_bitsel >> 1;
                    n_cnt    = '0;
                    n_idx    = '0;
                    if (r_bitsel[0]) begin
                        if (r_even) begin
                            n_min_vld = 1'b0;
                            n_state   = ST_FINAL;
                        end else begin
                            n_value = {n_prefix, 1'b0};
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_FINAL: begin
                if (r_rd_vld) begin
                    if (r_rd_data <= r_prefix) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (!r_min_vld || (r_rd_data < r_min)) begin
                        n_min     = r_rd_data;
                        n_min_vld = 1'b1;
                    end
                end
                if (w_pass_end) begin
                    n_value = {1'b0, r_prefix} + {1'b0, w_upper};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
        r_base    <= n_base;
        r_len     <= n_len;
        r_k       <= n_k;
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_even    <= n_even;
        r_prefix  <= n_prefix;
        r_mask    <= n_mask;
        r_bitsel  <= n_bitsel;
        r_min     <= n_min;
        r_min_vld <= n_min_vld;
        r_value   <= n_value;
    end

    assign o_rsp.done  = (r_state == ST_DONE);
    assign o_rsp.value = r_value;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == ST_IDLE))
        else $error("rank request while selector busy");

    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ack |-> (r_state == ST_DONE))
        else $error("rank acknowledge without a result");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) || (r_state == ST_FINAL)) |-> (r_k < r_len))
        else $error("target rank outside window");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) || (r_state == ST_FINAL)) |-> (r_cnt <= r_len))
        else $error("pass count exceeds window length");

    a_final_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINAL) && w_pass_end && (r_cnt <= (r_len >> 1))) |-> r_min_vld)
        else $error("upper middle value missing");

endmodule

// ===== rtl/sliding_window_median_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter_top
// median filter over a circular history of raw pressure samples
// ----------------------------------------------------------------------------
// The first 64 samples after reset fill the history and come back at once as
// twice the sample with the pass-through flag set; so does every sample while
// window_taps is 0. Otherwise the sample is stored and the result is twice
// the median of the newest window_taps+1 samples (an even window gives the
// sum of its two middle values). A median is found one bit of the value at
// a time, most significant first: each of the 24 bits costs one sweep over
// the window through the single read port of the history memory, and an
// even window adds one more sweep for the upper middle value. While a
// median is being found the input is not ready. A finished result waits
// in an output register, and the next sample is taken only once that
// register is empty or is being read in the same cycle.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [swmf_pkg::TAPS_W-1:0]        i_cfg_wr_data,  // window_taps
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [swmf_pkg::IN_TDATA_W-1:0]    i_s_tdata,      // sample
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [swmf_pkg::OUT_TDATA_W-1:0]   o_m_tdata,      // median_doubled
    output logic                               o_m_tuser       // passed_through
);

    logic [swmf_pkg::TAPS_W-1:0] r_taps;
    swmf_pkg::t_addr             r_slot;
    logic                        r_warm;
    logic                        r_busy;
    logic                        r_out_valid;
    swmf_pkg::t_result           r_out_data;
    logic                        r_out_pass;

    logic                        w_s_accept;
    logic                        w_out_free;
    logic                        w_len_one;
    logic                        w_pass;
    logic                        w_ack;
    swmf_pkg::t_sample           w_sample;
    swmf_pkg::t_addr             w_slot_next;
    logic [swmf_pkg::TAPS_W:0]   w_len_raw;
    swmf_pkg::t_len              w_len;
    swmf_pkg::t_rank_req         w_req;
    swmf_pkg::t_rank_rsp         w_rsp;

    assign w_sample    = i_s_tdata[swmf_pkg::SAMPLE_WIDTH-1:0];
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_busy && w_out_free;
    assign w_s_accept  = i_s_tvalid && o_s_tready;

    assign w_len_raw   = (swmf_pkg::TAPS_W + 1)'(r_taps) + 1'b1;
    assign w_len       = (w_len_raw > swmf_pkg::HISTORY_DEPTH)
                         ? swmf_pkg::LEN_W'(swmf_pkg::HISTORY_DEPTH)
                         : swmf_pkg::LEN_W'(w_len_raw);
    assign w_len_one   = (w_len == swmf_pkg::LEN_W'(1));
    assign w_pass      = !r_warm || w_len_one;
    assign w_slot_next = (r_slot == swmf_pkg::ADDR_W'(swmf_pkg::HISTORY_DEPTH - 1))
                         ? '0 : r_slot + 1'b1;

    assign w_req.start = w_s_accept && r_warm && !w_len_one;
    assign w_req.base  = r_slot;
    assign w_req.len   = w_len;
    assign w_ack       = r_busy && w_rsp.done && w_out_free;

    swmf_rank u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_s_accept && !(r_warm && w_len_one)),
        .i_wr_addr (r_slot),
        .i_wr_data (w_sample),
        .i_req     (w_req),
        .i_ack     (w_ack),
        .o_rsp     (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps      <= '0;
            r_slot      <= '0;
            r_warm      <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_taps <= i_cfg_wr_data;
            end
            if (w_s_accept && !(r_warm && w_len_one)) begin
                r_slot <= w_slot_next;
                if (!r_warm && (r_slot == swmf_pkg::ADDR_W'(swmf_pkg::HISTORY_DEPTH - 1))) begin
                    r_warm <= 1'b1;
                end
            end
            if (w_req.start) begin
                r_busy <= 1'b1;
            end else if (w_ack) begin
                r_busy <= 1'b0;
            end
            if ((w_s_accept && w_pass) || w_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_s_accept && w_pass) begin
            r_out_data <= {w_sample, 1'b0};
            r_out_pass <= 1'b1;
        end else if (w_ack) begin
            r_out_data <= w_rsp.value;
            r_out_pass <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = swmf_pkg::OUT_TDATA_W'(r_out_data);
    assign o_m_tuser  = r_out_pass;

endmodule
